// ----- design/sts_pkg.sv -----
// Shared types, codes and lookup functions for the source token scanner.
package sts_pkg;

  localparam int KEYWORD_CHARS_DEF = 8;
  localparam int POSITION_BITS_DEF = 32;
  localparam int FIFO_DEPTH        = 4;
  localparam int MAX_RESULTS       = 3;
  localparam int NUM_KEYWORDS      = 21;

  localparam logic [4:0] K_EOF    = 5'd0;
  localparam logic [4:0] K_KW0    = 5'd9;
  localparam logic [4:0] K_IDENT  = 5'd30;
  localparam logic [4:0] K_NUMBER = 5'd31;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_COMMENT = 2'd1,
    ERR_NUMBER  = 2'd2,
    ERR_UNKNOWN = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    MD_IDLE, MD_DASH1, MD_DASH2, MD_DASH3, MD_LINE,
    MD_BLOCK, MD_BLOCK_BR, MD_IDENT, MD_NUMBER, MD_UNKNOWN
  } mode_t;

  typedef enum logic [2:0] {
    N_START, N_INT, N_DOT, N_FRAC, N_EXP, N_ESIGN, N_EDIG, N_BAD
  } nsyn_t;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       src_last;
  } in_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [1:0]  error_code;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic        result_last;
  } out_t;

  typedef struct packed {
    logic       halted;
    logic [1:0] push_n;
  } scan_stat_t;

  // keyword text, left-justified, space padded
  localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
    "local   ", "function", "return  ", "if      ", "else    ",
    "elseif  ", "then    ", "for     ", "do      ", "and     ",
    "break   ", "in      ", "not     ", "or      ", "repeat  ",
    "until   ", "while   ", "end     ", "true    ", "false   ",
    "nil     "
  };
  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
    4'd5, 4'd8, 4'd6, 4'd2, 4'd4, 4'd6, 4'd4, 4'd3, 4'd2, 4'd3,
    4'd5, 4'd2, 4'd3, 4'd2, 4'd6, 4'd5, 4'd5, 4'd3, 4'd4, 4'd5, 4'd3
  };

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      "=":     k = 5'd1;
      "(":     k = 5'd2;
      ")":     k = 5'd3;
      "[":     k = 5'd4;
      "]":     k = 5'd5;
      "{":     k = 5'd6;
      "}":     k = 5'd7;
      ",":     k = 5'd8;
      default: k = 5'd0;
    endcase
    return k;
  endfunction

  function automatic nsyn_t num_next(input nsyn_t s, input logic [7:0] c);
    nsyn_t r;
    r = N_BAD;
    if (is_digit(c)) begin
      if (s == N_START || s == N_INT) r = N_INT;
      else if (s == N_DOT || s == N_FRAC) r = N_FRAC;
      else if (s == N_EXP || s == N_ESIGN || s == N_EDIG) r = N_EDIG;
    end else if (c == ".") begin
      if (s == N_START) r = N_DOT;
      else if (s == N_INT) r = N_FRAC;
    end else if (c == "e") begin
      if (s == N_INT || s == N_FRAC) r = N_EXP;
    end else if (c == "+" || c == "-") begin
      if (s == N_EXP) r = N_ESIGN;
    end
    return r;
  endfunction

  function automatic logic num_valid(input nsyn_t s);
    return s == N_INT || s == N_FRAC || s == N_EDIG;
  endfunction

  function automatic logic is_num_char(input logic [7:0] c);
    return is_digit(c) || c == "." || c == "e" || c == "-" || c == "+";
  endfunction

  // ch[j] is character j of the word; len is valid up to 8
  function automatic logic [4:0] kw_kind(input logic [7:0][7:0] ch, input logic [3:0] len);
    logic [4:0] k;
    logic       same;
    k = K_IDENT;
    for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
      same = (KW_LEN[i] == len);
      for (int j = 0; j < 8; j++) begin
        if (j < int'(KW_LEN[i]) && KW_TEXT[i][63-8*j -: 8] != ch[j]) same = 1'b0;
      end
      if (same) k = K_KW0 + 5'(i);
    end
    return k;
  endfunction

endpackage

// ----- design/source_token_scanner.sv -----
// A byte's results are written into the registered result queue and offered from its head.
// Throughput: one byte per cycle while the result queue holds at most one entry;
// in_ready is low whenever the 4-entry result queue holds more than one entry, as
// after a byte yielding two or three results or while out_ready holds it back.
// Reset: synchronous active-low rst_n returns to idle at offset 0, queue empty.
// After an error result, bytes are taken and dropped until reset.
module source_token_scanner import sts_pkg::*; #(
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  out_t       res [MAX_RESULTS];
  scan_stat_t stat;
  logic       acc, room;

  assign in_ready = room;
  assign acc      = in_valid && in_ready;

  sts_scanner #(
    .KEYWORD_CHARS(KEYWORD_CHARS),
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .in_data(in_data),
    .res    (res),
    .stat   (stat)
  );

  sts_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (stat.push_n),
    .push_data(res),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .room     (room)
  );

  a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    stat.halted |-> stat.push_n == 2'd0) else $error("request produced results after error");

  a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |-> stat.push_n == 2'd0) else $error("results without accepted request");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("queue not empty after reset");

  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.push_n != 2'd0) |-> res[stat.push_n - 2'd1].result_last)
    else $error("final result of a request not marked");

endmodule

// ----- design/sts_scanner.sv -----
// Per-byte scan logic and scanner state; yields up to three results per byte.
module sts_scanner import sts_pkg::*; #(
  parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  in_t        in_data,
  output out_t       res [MAX_RESULTS],
  output scan_stat_t stat
);

  localparam int LW  = (POSITION_BITS < 32) ? POSITION_BITS : 32;
  localparam int KIW = $clog2(KEYWORD_CHARS);

  mode_t                    mode_r, mode_nxt, mid_mode;
  nsyn_t                    nsyn_r, nsyn_nxt, mid_nsyn;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, pos_inc;
  logic [POSITION_BITS-1:0] origin_r, origin_nxt, mid_origin;
  logic [LW-1:0]            count_r, count_nxt, mid_count, count_inc;
  logic [7:0]               chars_r [KEYWORD_CHARS];
  logic [7:0]               mid_chars [KEYWORD_CHARS];
  logic                     halted_r, halted_nxt;

  logic       live, last, sp, wch, do_start;
  logic [7:0] c;
  logic       tok_v, err_v, punct_v, fin_tok_v, fin_err_v;
  logic [4:0] tok_kind, fin_kind, pk;
  err_t       err_code, fin_code;
  logic [LW-1:0] err_len, fin_len;

  function automatic logic [4:0] word_kind(input logic [7:0] ch [KEYWORD_CHARS],
                                           input logic [LW-1:0] cnt);
    logic [7:0][7:0] w;
    for (int j = 0; j < 8; j++) w[j] = ch[j];
    return (cnt > LW'(8)) ? K_IDENT : kw_kind(w, cnt[3:0]);
  endfunction

  function automatic logic [31:0] lo32(input logic [POSITION_BITS-1:0] p);
    logic [63:0] t;
    t = 64'(p);
    return t[31:0];
  endfunction

  assign c         = in_data.src_byte;
  assign last      = in_data.src_last;
  assign live      = acc && !halted_r;
  assign sp        = is_space(c);
  assign wch       = is_alpha(c) || is_digit(c) || c == "_";
  assign pk        = punct_kind(c);
  assign pos_inc   = pos_r + 1'b1;
  assign count_inc = (count_r == '1) ? count_r : count_r + 1'b1;

  // next state: one step of the scan, then end-of-input handling
  always_comb begin
    mid_mode   = mode_r;
    mid_nsyn   = nsyn_r;
    mid_origin = origin_r;
    mid_count  = count_r;
    mid_chars  = chars_r;
    tok_v      = 1'b0;
    tok_kind   = K_IDENT;
    err_v      = 1'b0;
    err_code   = ERR_NONE;
    err_len    = count_r;
    punct_v    = 1'b0;
    do_start   = 1'b0;
    case (mode_r)
      MD_IDLE: do_start = 1'b1;
      MD_DASH1: begin
        if (c == "-") begin
          mid_mode  = MD_DASH2;
          mid_count = count_inc;
        end else if (sp) begin
          err_v    = 1'b1;
          err_code = ERR_UNKNOWN;
        end else begin
          mid_mode  = MD_UNKNOWN;
          mid_count = count_inc;
        end
      end
      MD_DASH2: mid_mode = (c == "[") ? MD_DASH3 :
                           ((c == 8'h0a || c == 8'h0d) ? MD_IDLE : MD_LINE);
      MD_DASH3: mid_mode = (c == "[") ? MD_BLOCK :
                           ((c == 8'h0a || c == 8'h0d) ? MD_IDLE : MD_LINE);
      MD_LINE: if (c == 8'h0a || c == 8'h0d) mid_mode = MD_IDLE;
      MD_BLOCK: if (c == "]") mid_mode = MD_BLOCK_BR;
      MD_BLOCK_BR: mid_mode = (c == "]") ? MD_IDLE : MD_BLOCK;
      MD_IDENT: begin
        if (wch) begin
          if (count_r < LW'(KEYWORD_CHARS)) mid_chars[count_r[KIW-1:0]] = c;
          mid_count = count_inc;
        end else begin
          tok_v    = 1'b1;
          tok_kind = word_kind(chars_r, count_r);
          do_start = 1'b1;
        end
      end
      MD_NUMBER: begin
        if (is_num_char(c)) begin
          mid_nsyn  = num_next(nsyn_r, c);
          mid_count = count_inc;
        end else if (num_valid(nsyn_r)) begin
          tok_v    = 1'b1;
          tok_kind = K_NUMBER;
          do_start = 1'b1;
        end else begin
          err_v    = 1'b1;
          err_code = ERR_NUMBER;
        end
      end
      default: begin
        if (sp) begin
          err_v    = 1'b1;
          err_code = ERR_UNKNOWN;
        end else begin
          mid_count = count_inc;
        end
      end
    endcase

    if (do_start) begin
      mid_mode = MD_IDLE;
      if (!sp) begin
        if (pk != 5'd0) begin
          punct_v = 1'b1;
        end else begin
          mid_origin = pos_r;
          mid_count  = LW'(1);
          if (is_alpha(c) || c == "_") begin
            mid_mode     = MD_IDENT;
            mid_chars[0] = c;
          end else if (is_digit(c) || c == ".") begin
            mid_mode = MD_NUMBER;
            mid_nsyn = num_next(N_START, c);
          end else if (c == "-") begin
            mid_mode = MD_DASH1;
          end else begin
            mid_mode = MD_UNKNOWN;
          end
        end
      end
    end

    fin_tok_v = 1'b0;
    fin_err_v = 1'b0;
    fin_kind  = K_IDENT;
    fin_code  = ERR_NONE;
    fin_len   = mid_count;
    if (last && !err_v) begin
      case (mid_mode)
        MD_DASH1, MD_UNKNOWN: begin
          fin_err_v = 1'b1;
          fin_code  = ERR_UNKNOWN;
        end
        MD_BLOCK, MD_BLOCK_BR: begin
          fin_err_v = 1'b1;
          fin_code  = ERR_COMMENT;
          fin_len   = LW'(4);
        end
        MD_IDENT: begin
          fin_tok_v = 1'b1;
          fin_kind  = word_kind(mid_chars, mid_count);
        end
        MD_NUMBER: begin
          if (num_valid(mid_nsyn)) begin
            fin_tok_v = 1'b1;
            fin_kind  = K_NUMBER;
          end else begin
            fin_err_v = 1'b1;
            fin_code  = ERR_NUMBER;
          end
        end
        default: ;
      endcase
    end

    mode_nxt   = mode_r;
    nsyn_nxt   = nsyn_r;
    pos_nxt    = pos_r;
    origin_nxt = origin_r;
    count_nxt  = count_r;
    halted_nxt = halted_r;
    if (live) begin
      halted_nxt = err_v || fin_err_v;
      if (last && !err_v && !fin_err_v) begin
        mode_nxt   = MD_IDLE;
        nsyn_nxt   = N_START;
        pos_nxt    = '0;
        origin_nxt = '0;
        count_nxt  = '0;
      end else begin
        mode_nxt   = mid_mode;
        nsyn_nxt   = mid_nsyn;
        pos_nxt    = pos_inc;
        origin_nxt = mid_origin;
        count_nxt  = mid_count;
      end
    end
  end

  // outputs: results in the order the byte produces them
  always_comb begin
    logic [1:0] n;
    n = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) res[i] = '0;
    if (tok_v) begin
      res[n] = '{tok_kind, ERR_NONE, lo32(origin_r), 32'(count_r), 1'b0};
      n = n + 1'b1;
    end else if (err_v) begin
      res[n] = '{K_EOF, err_code, lo32(origin_r), 32'(err_len), 1'b0};
      n = n + 1'b1;
    end
    if (punct_v) begin
      res[n] = '{pk, ERR_NONE, lo32(pos_r), 32'd1, 1'b0};
      n = n + 1'b1;
    end
    if (fin_tok_v) begin
      res[n] = '{fin_kind, ERR_NONE, lo32(mid_origin), 32'(mid_count), 1'b0};
      n = n + 1'b1;
    end else if (fin_err_v) begin
      res[n] = '{K_EOF, fin_code, lo32(mid_origin), 32'(fin_len), 1'b0};
      n = n + 1'b1;
    end
    if (last && !err_v && !fin_err_v) begin
      res[n] = '{K_EOF, ERR_NONE, lo32(pos_inc), 32'd0, 1'b0};
      n = n + 1'b1;
    end
    if (n != 2'd0) res[n - 1'b1].result_last = 1'b1;
    stat.halted = halted_r;
    stat.push_n = live ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MD_IDLE;
      nsyn_r   <= N_START;
      pos_r    <= '0;
      origin_r <= '0;
      count_r  <= '0;
      halted_r <= 1'b0;
      for (int i = 0; i < KEYWORD_CHARS; i++) chars_r[i] <= '0;
    end else begin
      mode_r   <= mode_nxt;
      nsyn_r   <= nsyn_nxt;
      pos_r    <= pos_nxt;
      origin_r <= origin_nxt;
      count_r  <= count_nxt;
      halted_r <= halted_nxt;
      if (live) chars_r <= mid_chars;
    end
  end

endmodule

// ----- design/sts_result_fifo.sv -----
// Small result queue: takes up to three results a cycle, gives one.
module sts_result_fifo import sts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_n,
  input  out_t       push_data [MAX_RESULTS],
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  output logic       room
);

  localparam int PW = $clog2(FIFO_DEPTH);

  out_t          mem_r [FIFO_DEPTH];
  logic [PW-1:0] rd_r, rd_nxt, wr_r, wr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r <= (PW+1)'(FIFO_DEPTH - MAX_RESULTS));
  assign rd_nxt    = rd_r + PW'(pop);
  assign wr_nxt    = wr_r + PW'(push_n);
  assign cnt_nxt   = cnt_r - (PW+1)'(pop) + (PW+1)'(push_n);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < push_n) mem_r[wr_r + PW'(i)] <= push_data[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench for the source token scanner: byte stimulus, token prediction, result checking.
`timescale 1ns / 100ps

module tb;
  import sts_pkg::*;

  localparam int KW_CHARS = 8;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  source_token_scanner uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predictor state
  mode_t       sc_mode;
  logic [31:0] sc_pos;
  logic [31:0] sc_origin;
  logic [7:0]  sc_chars [KW_CHARS];
  logic [31:0] sc_count;
  nsyn_t       sc_num;
  logic        sc_halted;

  out_t token_q[$];
  int   n_fail;
  int   cycles;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_off;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic bit sp(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit alp(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [4:0] punct_of(input logic [7:0] c);
    case (c)
      "=": return 5'd1;
      "(": return 5'd2;
      ")": return 5'd3;
      "[": return 5'd4;
      "]": return 5'd5;
      "{": return 5'd6;
      "}": return 5'd7;
      ",": return 5'd8;
      default: return 5'd0;
    endcase
  endfunction

  function automatic nsyn_t num_step(input nsyn_t s, input logic [7:0] c);
    if (dig(c)) begin
      if (s == N_START || s == N_INT) return N_INT;
      if (s == N_DOT || s == N_FRAC) return N_FRAC;
      if (s == N_EXP || s == N_ESIGN || s == N_EDIG) return N_EDIG;
      return N_BAD;
    end
    if (c == ".") return (s == N_START) ? N_DOT : (s == N_INT) ? N_FRAC : N_BAD;
    if (c == "e") return (s == N_INT || s == N_FRAC) ? N_EXP : N_BAD;
    if (c == "+" || c == "-") return (s == N_EXP) ? N_ESIGN : N_BAD;
    return N_BAD;
  endfunction

  function automatic bit num_ok(input nsyn_t s);
    return s == N_INT || s == N_FRAC || s == N_EDIG;
  endfunction

  function automatic bit num_char(input logic [7:0] c);
    return dig(c) || c == "." || c == "e" || c == "-" || c == "+";
  endfunction

  function automatic logic [4:0] word_class();
    string kws [21];
    string w;
    kws = '{"local", "function", "return", "if", "else", "elseif", "then", "for",
            "do", "and", "break", "in", "not", "or", "repeat", "until", "while",
            "end", "true", "false", "nil"};
    if (sc_count > KW_CHARS) return K_IDENT;
    w = "";
    for (int i = 0; i < sc_count; i++) w = {w, string'(sc_chars[i])};
    for (int i = 0; i < 21; i++)
      if (kws[i] == w) return K_KW0 + 5'(i);
    return K_IDENT;
  endfunction

  task automatic push_token(input logic [4:0] k, input err_t e,
                            input logic [31:0] st, input logic [31:0] ln, ref int n);
    out_t r;
    r.token_kind = k;
    r.error_code = e;
    r.token_start = st;
    r.token_length = ln;
    r.result_last = 1'b0;
    token_q.push_back(r);
    n++;
  endtask

  task automatic push_error(input err_t e, input logic [31:0] ln, ref int n);
    sc_halted = 1'b1;
    push_token(K_EOF, e, sc_origin, ln, n);
  endtask

  task automatic bump();
    if (sc_count != 32'hFFFF_FFFF) sc_count++;
  endtask

  task automatic begin_token(input logic [7:0] c, input logic [31:0] p, ref int n);
    logic [4:0] pk;
    pk = punct_of(c);
    sc_mode = MD_IDLE;
    if (sp(c)) return;
    if (pk != 0) begin
      push_token(pk, ERR_NONE, p, 32'd1, n);
      return;
    end
    sc_origin = p;
    sc_count = 1;
    if (alp(c) || c == "_") begin
      sc_mode = MD_IDENT;
      sc_chars[0] = c;
    end else if (dig(c) || c == ".") begin
      sc_mode = MD_NUMBER;
      sc_num = num_step(N_START, c);
    end else if (c == "-") begin
      sc_mode = MD_DASH1;
    end else begin
      sc_mode = MD_UNKNOWN;
    end
  endtask

  task automatic scanner_reset();
    sc_mode = MD_IDLE;
    sc_pos = 0;
    sc_origin = 0;
    foreach (sc_chars[i]) sc_chars[i] = 8'd0;
    sc_count = 0;
    sc_num = N_START;
    sc_halted = 1'b0;
  endtask

  task automatic predict_tokens(input in_t it);
    logic [7:0]  c;
    logic [31:0] p;
    bit          nl;
    int          n;
    c = it.src_byte;
    p = sc_pos;
    nl = (c == 8'h0A || c == 8'h0D);
    n = 0;
    if (sc_halted) return;
    case (sc_mode)
      MD_IDLE: begin_token(c, p, n);
      MD_DASH1: begin
        if (c == "-") begin
          sc_mode = MD_DASH2;
          bump();
        end else if (sp(c)) begin
          push_error(ERR_UNKNOWN, sc_count, n);
        end else begin
          sc_mode = MD_UNKNOWN;
          bump();
        end
      end
      MD_DASH2: sc_mode = (c == "[") ? MD_DASH3 : (nl ? MD_IDLE : MD_LINE);
      MD_DASH3: sc_mode = (c == "[") ? MD_BLOCK : (nl ? MD_IDLE : MD_LINE);
      MD_LINE: if (nl) sc_mode = MD_IDLE;
      MD_BLOCK: if (c == "]") sc_mode = MD_BLOCK_BR;
      MD_BLOCK_BR: sc_mode = (c == "]") ? MD_IDLE : MD_BLOCK;
      MD_IDENT: begin
        if (alp(c) || dig(c) || c == "_") begin
          if (sc_count < KW_CHARS) sc_chars[sc_count] = c;
          bump();
        end else begin
          push_token(word_class(), ERR_NONE, sc_origin, sc_count, n);
          begin_token(c, p, n);
        end
      end
      MD_NUMBER: begin
        if (num_char(c)) begin
          sc_num = num_step(sc_num, c);
          bump();
        end else if (num_ok(sc_num)) begin
          push_token(K_NUMBER, ERR_NONE, sc_origin, sc_count, n);
          begin_token(c, p, n);
        end else begin
          push_error(ERR_NUMBER, sc_count, n);
        end
      end
      default: begin
        if (sp(c)) push_error(ERR_UNKNOWN, sc_count, n);
        else bump();
      end
    endcase
    sc_pos = p + 1;
    if (!sc_halted && it.src_last) begin
      case (sc_mode)
        MD_DASH1, MD_UNKNOWN: push_error(ERR_UNKNOWN, sc_count, n);
        MD_BLOCK, MD_BLOCK_BR: push_error(ERR_COMMENT, 32'd4, n);
        MD_IDENT: push_token(word_class(), ERR_NONE, sc_origin, sc_count, n);
        MD_NUMBER: begin
          if (num_ok(sc_num)) push_token(K_NUMBER, ERR_NONE, sc_origin, sc_count, n);
          else push_error(ERR_NUMBER, sc_count, n);
        end
        default: ;
      endcase
      if (!sc_halted) begin
        push_token(K_EOF, ERR_NONE, sc_pos, 32'd0, n);
        sc_mode = MD_IDLE;
        sc_pos = 0;
        sc_origin = 0;
        sc_count = 0;
        sc_num = N_START;
      end
    end
    if (n > 0) token_q[$].result_last = 1'b1;
  endtask

  // one request: hold valid until taken, predict at the accepting edge;
  // valid drops only when the sender idles or the stream stops
  task automatic send_byte(input logic [7:0] c, input bit last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{src_byte: c, src_last: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tokens('{src_byte: c, src_last: last});
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], last && i == s.len() - 1);
  endtask

  always @(negedge clk) begin
    out_ready <= !hold_off &&
                 !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (token_q.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, out_data);
        n_fail++;
      end else begin
        want = token_q.pop_front();
        if (out_data !== want) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, want, out_data);
          n_fail++;
        end
      end
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // the scanner halts on errors, so each error case gets its own reset-free flow:
  // a halted block drops bytes, which the predictor also ignores.
  task automatic test_tokens();
    send_text("local function return if else elseif then for do and break ", 0);
    send_text("in not or repeat until while end true false nil x_1 ", 0);
    send_text("=()[]{}, abcdefghij _ Zz9 ", 0);
    send_text("12 3.5 .5 7e+3 1.5e-2 4e9 ", 0);
    send_text("-- line comment\n--[[ block ]x] ]]--\r--[x\n", 0);
    send_text("elseif", 1);
    drain();
  endtask

  task automatic test_unknown();
    send_text("a - b", 1);
    drain();
  endtask

  function automatic string rand_chunk();
    string frags [] = '{"local", "function", "elseif", "repeat", "until", "x", "ab_c9",
                        "longidentifier", "123", "4.25", "6e-7", ".5", "=", "(", ")",
                        "[", "]", "{", "}", ",", "--c\n", "--[[z]]", "_", "end", "nil"};
    string ws [] = '{" ", "\t", "\n", "\r", "  "};
    return {frags[$urandom_range(frags.size() - 1)], ws[$urandom_range(ws.size() - 1)]};
  endfunction

  // random well-formed sources, with a noisy one at the end if noisy_end is set; reset between
  // halted sources is not allowed, so a noisy source is the last of a phase
  task automatic test_random(input int n_bytes, input bit noisy_end);
    int sent;
    string s;
    sent = 0;
    while (sent < n_bytes) begin
      s = rand_chunk();
      send_text(s, $urandom_range(7) == 0);
      sent += s.len();
    end
    if (noisy_end) begin
      for (int i = 0; i < 12; i++) send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b1);
    end else begin
      send_byte(" ", 1'b1);
    end
    drain();
  endtask

  task automatic test_back_pressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(negedge clk);
        hold_off = 1'b0;
      end
      send_text("= ( ) [ ] { } , = = = ( ) a b c", 1);
    join
    drain();
  endtask

  initial begin
    n_fail = 0;
    cycles = 0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    scanner_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_tokens();
    test_back_pressure();
    test_random(10, 0);
    send_idle_pct = 86;
    test_random(10, 0);
    send_idle_pct = 0;
    recv_stall_pct = 86;
    test_random(10, 0);
    send_idle_pct = 13;
    recv_stall_pct = 13;
    test_random(10, 1);
    // halted now: remaining bytes are dropped, including an unknown-run case
    test_unknown();
    repeat (20) @(negedge clk);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
